### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL files; empty when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### design/itcrt_pkg.sv
// ---------------------------------------------------------------------------
// itcrt_pkg
// Shared types and constants for the integer to radix text converter.
// ---------------------------------------------------------------------------
package itcrt_pkg;

   // Alphabet limits
   localparam int MAX_RADIX    = 32;
   localparam int CHAR_SLOTS   = 32;
   localparam int DIGIT_SLOTS  = 32;
   localparam int DIV_BITS     = 8;                 // quotient bits per cycle
   localparam int DIV_STEPS    = 32 / DIV_BITS;     // division slices per digit

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_CHARS_A = 3'd0;
   localparam logic [2:0] CSR_CHARS_B = 3'd1;
   localparam logic [2:0] CSR_CHARS_C = 3'd2;
   localparam logic [2:0] CSR_CHARS_D = 3'd3;
   localparam logic [2:0] CSR_RADIX   = 3'd4;

   // Character codes
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_PERCENT  = 8'h25;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_EQUAL    = 8'h3D;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_MIN      = 8'd33;
   localparam logic [7:0] CH_MAX      = 8'd126;
   localparam logic [7:0] CH_NONE     = 8'h00;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture the input and start a check
      logic val_step;    // check one alphabet character
      logic div_step;    // run one slice of the division
      logic emit_sign;   // send the minus sign
      logic emit_digit;  // send the next stored digit
      logic emit_error;  // send the bad alphabet result
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic bad;         // alphabet found invalid so far
      logic val_last;    // checking the final alphabet character
      logic div_last;    // final slice of the current division
      logic quot_zero;   // quotient of the current division is zero
      logic neg;         // input was negative
      logic digit_last;  // one stored digit left
   } stat_type;

endpackage

### design/integer_to_custom_radix_text.sv
// ---------------------------------------------------------------------------
// integer_to_custom_radix_text
// Writes a signed 32-bit integer as text in a radix set by a configured
// alphabet; an invalid alphabet gives a single error result.
// ---------------------------------------------------------------------------
// Busy while an item is checked, divided and sent; the next item can be taken as soon
//   as busy drops. 8 quotient bits/cycle.
// Invalid alphabet, by a bad length or a bad character: one error result.
// After the first result the rest follow one per cycle; the
//   receiver cannot stall, results are strobes.
// Synchronous reset clears the alphabet registers, the controller and the strobe.
module integer_to_custom_radix_text
   import itcrt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_number,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_character,
   output logic               rsp_bad_alphabet,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // Sequence one item at a time
   itcrt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Check, divide, store and send
   itcrt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_number       (req_number),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_character    (rsp_character),
      .rsp_bad_alphabet (rsp_bad_alphabet),
      .rsp_last         (rsp_last)
   );

endmodule

### design/itcrt_dp.sv
// ---------------------------------------------------------------------------
// itcrt_dp
// Datapath: alphabet registers, alphabet check, digit division, digit store
// and registered result outputs.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module itcrt_dp
   import itcrt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic signed [31:0] req_number,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   input  cmd_type            cmd,
   output stat_type           stat,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_character,
   output logic               rsp_bad_alphabet,
   output logic               rsp_last
);

   logic [3:0][63:0] alpha_ff;
   logic [5:0]       radix_ff;
   logic             neg_ff,     neg_in;
   logic [31:0]      mag_ff,     mag_in;
   logic             bad_ff,     bad_in;
   logic [4:0]       val_idx_ff, val_idx_in;
   logic [4:0]       rem_ff,     rem_in;
   logic [1:0]       step_ff,    step_in;
   logic [5:0]       nd_ff,      nd_in;
   logic [4:0]       digits_ff [DIGIT_SLOTS];
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]       rsp_char_ff,   rsp_char_in;
   logic             rsp_bad_ff,    rsp_bad_in;
   logic             rsp_last_ff,   rsp_last_in;

   logic [31:0]      raw;
   logic [7:0]       val_char;
   logic             val_fail;
   logic             dup;
   logic [DIV_BITS-1:0] qbits;
   logic [5:0]       div_rem;
   logic [31:0]      quot_next;
   logic [4:0]       emit_idx;

   function automatic logic [7:0] char_at(input logic [3:0][63:0] a, input logic [4:0] k);
      char_at = a[k[4:3]][{k[2:0], 3'b000} +: 8];
   endfunction

   // Write configuration registers; unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
         radix_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index) inside
            CSR_CHARS_A, CSR_CHARS_B, CSR_CHARS_C, CSR_CHARS_D: begin
               alpha_ff[csr_index[1:0]] <= csr_wdata;
            end
            CSR_RADIX: begin
               radix_ff <= csr_wdata[5:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Check one alphabet character against range, reserved set and later slots
   always_comb begin
      val_char = char_at(alpha_ff, val_idx_ff);
      dup      = 1'b0;
      for (int j = 0; j < CHAR_SLOTS; j++) begin
         if ((6'(j) > {1'b0, val_idx_ff}) && (6'(j) < radix_ff) &&
             (char_at(alpha_ff, 5'(j)) == val_char)) begin
            dup = 1'b1;
         end
      end
      val_fail = (val_char < CH_MIN) || (val_char > CH_MAX) ||
                 (val_char == CH_PLUS) || (val_char == CH_MINUS) ||
                 (val_char == CH_PERCENT) || (val_char == CH_SLASH) ||
                 (val_char == CH_STAR) || (val_char == CH_EQUAL) ||
                 (val_char == CH_COMMA) || (val_char == CH_DOT) || dup;
   end

   // Long division slice: shift in the top dividend bits, one quotient bit each
   always_comb begin
      div_rem = {1'b0, rem_ff};
      qbits   = '0;
      for (int b = 0; b < DIV_BITS; b++) begin
         div_rem = {div_rem[4:0], mag_ff[31-b]};
         if (div_rem >= radix_ff) begin
            div_rem             = div_rem - radix_ff;
            qbits[DIV_BITS-1-b] = 1'b1;
         end
      end
      quot_next = {mag_ff[31-DIV_BITS:0], qbits};
   end

   assign raw      = unsigned'(req_number);
   assign emit_idx = 5'(nd_ff - 6'd1);

   // Next state of the working registers
   always_comb begin
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      bad_in     = bad_ff;
      val_idx_in = val_idx_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      nd_in      = nd_ff;
      if (cmd.load) begin
         neg_in     = raw[31];
         mag_in     = raw[31] ? (32'd0 - raw) : raw;
         bad_in     = (radix_ff < 6'd2) || (radix_ff > 6'(MAX_RADIX)) ||
                      (radix_ff > 6'(CHAR_SLOTS));
         val_idx_in = '0;
         rem_in     = '0;
         step_in    = '0;
         nd_in      = '0;
      end else if (cmd.val_step) begin
         bad_in     = bad_ff | val_fail;
         val_idx_in = val_idx_ff + 5'd1;
      end else if (cmd.div_step) begin
         mag_in  = quot_next;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'(DIV_STEPS - 1)) begin
            rem_in = '0;
            nd_in  = nd_ff + 6'd1;
         end else begin
            rem_in = div_rem[4:0];
         end
      end else if (cmd.emit_digit) begin
         nd_in = nd_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      bad_ff     <= bad_in;
      val_idx_ff <= val_idx_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      nd_ff      <= nd_in;
   end

   // Store the finished remainder as the next digit, least significant first
   always_ff @(posedge clock) begin
      if (cmd.div_step && (step_ff == 2'(DIV_STEPS - 1))) begin
         digits_ff[nd_ff[4:0]] <= div_rem[4:0];
      end
   end

   // Form the next result
   always_comb begin
      rsp_strobe_in = cmd.emit_sign | cmd.emit_digit | cmd.emit_error;
      rsp_char_in   = CH_NONE;
      rsp_bad_in    = 1'b0;
      rsp_last_in   = 1'b0;
      if (cmd.emit_error) begin
         rsp_bad_in  = 1'b1;
         rsp_last_in = 1'b1;
      end else if (cmd.emit_sign) begin
         rsp_char_in = CH_MINUS;
      end else if (cmd.emit_digit) begin
         rsp_char_in = char_at(alpha_ff, digits_ff[emit_idx]);
         rsp_last_in = (nd_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign stat.bad        = bad_ff;
   assign stat.val_last   = ({1'b0, val_idx_ff} == (radix_ff - 6'd1));
   assign stat.div_last   = (step_ff == 2'(DIV_STEPS - 1));
   assign stat.quot_zero  = (quot_next == 32'd0);
   assign stat.neg        = neg_ff;
   assign stat.digit_last = (nd_ff == 6'd1);

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_character    = rsp_char_ff;
   assign rsp_bad_alphabet = rsp_bad_ff;
   assign rsp_last         = rsp_last_ff;

   `ASSERT_IMPL(a_emit_has_digit, clock, reset, cmd.emit_digit, nd_ff != 6'd0, "digit emitted from empty store")
   `ASSERT_IMPL(a_bad_is_last, clock, reset, rsp_strobe_ff && rsp_bad_ff, rsp_last_ff && (rsp_char_ff == CH_NONE), "error result not final")

endmodule

### design/itcrt_ctrl.sv
// ---------------------------------------------------------------------------
// itcrt_ctrl
// Controller: sequences the alphabet check, the digit divisions and the
// output of sign and digits for one item at a time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module itcrt_ctrl
   import itcrt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_VALID = 7'b0000010,
      S_CHECK = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_SIGN  = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_ERROR = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_VALID;
            end
         end
         S_VALID: begin
            if (stat.bad) begin
               state_in = S_ERROR;
            end else begin
               cmd.val_step = 1'b1;
               if (stat.val_last) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            state_in = stat.bad ? S_ERROR : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last && stat.quot_zero) begin
               state_in = stat.neg ? S_SIGN : S_EMIT;
            end
         end
         S_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit_digit = 1'b1;
            if (stat.digit_last) begin
               state_in = S_IDLE;
            end
         end
         S_ERROR: begin
            cmd.emit_error = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `ASSERT_NEXT(a_start_enters_check, clock, reset, start && !busy, state_ff == S_VALID, "accepted item did not start a check")
   `ASSERT_NEXT(a_div_holds, clock, reset, (state_ff == S_DIV) && !stat.div_last, state_ff == S_DIV, "division left early")

endmodule
